/* rtl/vboc_pkg.sv */
// Shared constants, register codes and types of the brick occupancy counter.
package vboc_pkg;

  localparam int unsigned MaxBricksPerAxis = 128;
  localparam int unsigned BrickEdge        = 32;
  localparam int unsigned MaxExtent        = 4096;

  localparam int unsigned PosW       = $clog2(MaxExtent);
  localparam int unsigned EdgeW      = $clog2(BrickEdge);
  localparam int unsigned BrickW     = PosW - EdgeW;
  localparam int unsigned AxisW      = $clog2(MaxBricksPerAxis);
  localparam int unsigned IdxW       = 2 * AxisW;
  localparam int unsigned StoreDepth = MaxBricksPerAxis * MaxBricksPerAxis;
  localparam int unsigned CmpW       = 16;

  localparam int unsigned ValW     = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned TallyW   = 22;
  localparam int unsigned AxisCntW = 8;
  localparam int unsigned ProdXyW  = 2 * AxisCntW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ValW-1:0]     LowReset   = ValW'(10);
  localparam logic [ValW-1:0]     HighReset  = ValW'(255);
  localparam logic [CountW-1:0]   MinReset   = CountW'(1639);
  localparam logic [AxisCntW-1:0] BricksReset = AxisCntW'(124);
  localparam logic [AxisCntW-1:0] AxisMax    = AxisCntW'(MaxBricksPerAxis);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW       = 3'd0,
    CFG_HIGH      = 3'd1,
    CFG_MIN_COUNT = 3'd2,
    CFG_BRICKS_X  = 3'd3,
    CFG_BRICKS_Y  = 3'd4,
    CFG_BRICKS_Z  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ValW-1:0]     low;
    logic [ValW-1:0]     high;
    logic [CountW-1:0]   min_count;
    logic [AxisCntW-1:0] nx;
    logic [AxisCntW-1:0] ny;
    logic [AxisCntW-1:0] nz;
    logic [TallyW-1:0]   total;
    logic                busy;
  } cfg_t;

endpackage

/* rtl/vboc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vboc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/vboc_cfg.sv */
// Configuration registers, axis clamping and the pipelined total brick product.
module vboc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vboc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vboc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output vboc_pkg::cfg_t                cfg_o
);

  logic [vboc_pkg::ValW-1:0]     low_q, high_q;
  logic [vboc_pkg::CountW-1:0]   min_q;
  logic [vboc_pkg::AxisCntW-1:0] bx_q, by_q, bz_q;
  logic [vboc_pkg::AxisCntW-1:0] nx, ny, nz;
  logic [vboc_pkg::ProdXyW-1:0]  prod_xy_q;
  logic [vboc_pkg::TallyW-1:0]   total_q;
  logic                          busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= vboc_pkg::LowReset;
      high_q <= vboc_pkg::HighReset;
      min_q  <= vboc_pkg::MinReset;
      bx_q   <= vboc_pkg::BricksReset;
      by_q   <= vboc_pkg::BricksReset;
      bz_q   <= vboc_pkg::BricksReset;
      busy_q <= 1'b0;
    end else begin
      busy_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (vboc_pkg::cfg_idx_e'(cfg_index_i))
          vboc_pkg::CFG_LOW:       low_q  <= cfg_wdata_i[vboc_pkg::ValW-1:0];
          vboc_pkg::CFG_HIGH:      high_q <= cfg_wdata_i[vboc_pkg::ValW-1:0];
          vboc_pkg::CFG_MIN_COUNT: min_q  <= cfg_wdata_i[vboc_pkg::CountW-1:0];
          vboc_pkg::CFG_BRICKS_X:  bx_q   <= cfg_wdata_i[vboc_pkg::AxisCntW-1:0];
          vboc_pkg::CFG_BRICKS_Y:  by_q   <= cfg_wdata_i[vboc_pkg::AxisCntW-1:0];
          vboc_pkg::CFG_BRICKS_Z:  bz_q   <= cfg_wdata_i[vboc_pkg::AxisCntW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign nx = (bx_q > vboc_pkg::AxisMax) ? vboc_pkg::AxisMax : bx_q;
  assign ny = (by_q > vboc_pkg::AxisMax) ? vboc_pkg::AxisMax : by_q;
  assign nz = (bz_q > vboc_pkg::AxisMax) ? vboc_pkg::AxisMax : bz_q;

  // two multiply stages, prod_xy_q then total_q; the product settles through both after a write
  always_ff @(posedge clk_i) begin
    prod_xy_q <= vboc_pkg::ProdXyW'(nx) * vboc_pkg::ProdXyW'(ny);
    total_q   <= vboc_pkg::TallyW'(prod_xy_q) * vboc_pkg::TallyW'(nz);
  end

  always_comb begin
    cfg_o.low       = low_q;
    cfg_o.high      = high_q;
    cfg_o.min_count = min_q;
    cfg_o.nx        = nx;
    cfg_o.ny        = ny;
    cfg_o.nz        = nz;
    cfg_o.total     = total_q;
    cfg_o.busy      = cfg_we_i | busy_q;
  end

endmodule

/* rtl/volume_block_occupancy_counter.sv */
// Top level: voxel intake, brick counter read-modify-write and result register.
// Throughput: one voxel per cycle outside clearing, configuration writes and
// report stalls, set by the single read and write port pair of the brick counter
// RAM (read on accept, write from the s1 stage). The result is registered when
// the last voxel leaves s1. Reset: a clearing pass zeroes the whole counter RAM;
// no voxel is taken meanwhile, nor during a config write or while busy_q is set.
module volume_block_occupancy_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vboc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vboc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vboc_pkg::ValW-1:0]     voxel_i,
  input  logic [vboc_pkg::PosW-1:0]     pos_x_i,
  input  logic [vboc_pkg::PosW-1:0]     pos_y_i,
  input  logic [vboc_pkg::PosW-1:0]     pos_z_i,
  input  logic                          last_voxel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vboc_pkg::TallyW-1:0]   valid_bricks_o,
  output logic [vboc_pkg::TallyW-1:0]   total_bricks_o
);

  vboc_pkg::cfg_t cfg;

  vboc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Intake decode
  logic [vboc_pkg::BrickW-1:0] bx, by, bz;
  logic                        in_hit, in_corner, in_occ, accept;
  logic [vboc_pkg::IdxW-1:0]   in_idx;

  assign bx = pos_x_i[vboc_pkg::PosW-1:vboc_pkg::EdgeW];
  assign by = pos_y_i[vboc_pkg::PosW-1:vboc_pkg::EdgeW];
  assign bz = pos_z_i[vboc_pkg::PosW-1:vboc_pkg::EdgeW];

  assign in_hit = (vboc_pkg::CmpW'(bx) < vboc_pkg::CmpW'(cfg.nx)) &&
                  (vboc_pkg::CmpW'(by) < vboc_pkg::CmpW'(cfg.ny)) &&
                  (vboc_pkg::CmpW'(bz) < vboc_pkg::CmpW'(cfg.nz));
  assign in_corner = (&pos_x_i[vboc_pkg::EdgeW-1:0]) &&
                     (&pos_y_i[vboc_pkg::EdgeW-1:0]) &&
                     (&pos_z_i[vboc_pkg::EdgeW-1:0]);
  assign in_occ = (voxel_i >= cfg.low) && (voxel_i <= cfg.high);
  assign in_idx = {vboc_pkg::AxisW'(by), vboc_pkg::AxisW'(bx)};

  // Pipeline and control registers
  logic                          s1_valid_q, s1_hit_q, s1_corner_q, s1_occ_q, s1_last_q;
  logic [vboc_pkg::IdxW-1:0]     s1_idx_q;
  logic                          fwd_valid_q;
  logic [vboc_pkg::IdxW-1:0]     fwd_idx_q;
  logic [vboc_pkg::CountW-1:0]   fwd_data_q;
  logic                          clr_busy_q;
  logic [vboc_pkg::IdxW-1:0]     clr_addr_q;
  logic [vboc_pkg::TallyW-1:0]   tally_q, tally_d, tally_inc;
  logic                          out_valid_q;
  logic [vboc_pkg::TallyW-1:0]   out_tally_q;
  logic                          s1_stall, s1_adv;

  assign s1_stall   = s1_valid_q && s1_last_q && out_valid_q && !out_ready_i;
  assign s1_adv     = s1_valid_q && !s1_stall;
  assign in_ready_o = !clr_busy_q && !cfg.busy && !s1_stall;
  assign accept     = in_valid_i && in_ready_o;

  // Counter RAM
  logic                        ram_we;
  logic [vboc_pkg::IdxW-1:0]   ram_waddr;
  logic [vboc_pkg::CountW-1:0] ram_wdata, ram_rdata, base, cnt_inc, wr_val;
  logic                        brick_ok;

  vboc_ram #(
    .Width (vboc_pkg::CountW),
    .Depth (vboc_pkg::StoreDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // Forward the write that landed on the same edge as this request's read
  assign base    = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_data_q : ram_rdata;
  assign cnt_inc = (s1_occ_q && base != '1) ? base + vboc_pkg::CountW'(1) : base;
  assign brick_ok = s1_hit_q && s1_corner_q && (cnt_inc >= cfg.min_count);
  assign wr_val  = s1_corner_q ? '0 : cnt_inc;

  assign tally_inc = (brick_ok && tally_q != '1) ? tally_q + vboc_pkg::TallyW'(1) : tally_q;
  assign tally_d   = s1_last_q ? '0 : tally_inc;

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_adv && s1_hit_q;
      ram_waddr = s1_idx_q;
      ram_wdata = wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + vboc_pkg::IdxW'(1);
        if (clr_addr_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (!s1_stall) begin
        s1_valid_q  <= accept;
        fwd_valid_q <= s1_adv && s1_hit_q;
      end
      if (s1_adv) begin
        tally_q <= tally_d;
      end
      if (s1_adv && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q    <= in_idx;
      s1_hit_q    <= in_hit;
      s1_corner_q <= in_corner;
      s1_occ_q    <= in_occ;
      s1_last_q   <= last_voxel_i;
    end
    if (!s1_stall) begin
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= wr_val;
    end
    if (s1_adv && s1_last_q) begin
      out_tally_q <= tally_inc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign valid_bricks_o = out_tally_q;
  assign total_bricks_o = cfg.total;

  // Checks
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_valid_q)
    else $error("voxel in flight during counter clearing");

  a_tally_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (tally_q == '0))
    else $error("valid tally not restarted after report");

  a_accept_reaches_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted voxel lost before counter update");

  a_tally_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_last_q) |=> (tally_q >= $past(tally_q)))
    else $error("valid tally decreased within a volume");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_stall |=> (s1_valid_q && $stable(s1_idx_q) && $stable(tally_q)))
    else $error("counter stage changed while stalled");

endmodule

/* tb/sv/volume_block_occupancy_counter_test.sv */
// Self-checking bench for the brick occupancy counter: voxel requests in, brick reports checked.
module volume_block_occupancy_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vboc_pkg::*;

  // The slowest run includes the clearing pass and long stalls.
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldoffCycles = 400;
  localparam int unsigned PhaseItems    = 105;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [TallyW-1:0] TallyMax = '1;

  typedef struct packed {
    logic [TallyW-1:0] valid_bricks;
    logic [TallyW-1:0] total_bricks;
  } brick_report_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i  = CFG_LOW;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [ValW-1:0]     voxel_i      = '0;
  logic [PosW-1:0]     pos_x_i      = '0;
  logic [PosW-1:0]     pos_y_i      = '0;
  logic [PosW-1:0]     pos_z_i      = '0;
  logic                last_voxel_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [TallyW-1:0]   valid_bricks_o;
  logic [TallyW-1:0]   total_bricks_o;

  // Predictor state: window, brick geometry, per-brick counts and the running tally.
  logic [ValW-1:0]     win_low;
  logic [ValW-1:0]     win_high;
  logic [CountW-1:0]   min_occ;
  logic [AxisCntW-1:0] n_x;
  logic [AxisCntW-1:0] n_y;
  logic [AxisCntW-1:0] n_z;
  logic [CountW-1:0]   occ_count [StoreDepth];
  logic [TallyW-1:0]   good_bricks;
  brick_report_t       pending_reports [$];

  int unsigned errors        = 0;
  int unsigned voxels_sent   = 0;
  int unsigned cycles        = 0;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned holdoff_reqs  = 0;
  int unsigned holdoff_seen  = 0;
  int unsigned holdoff_left  = 0;

  volume_block_occupancy_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .voxel_i        (voxel_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .last_voxel_i   (last_voxel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .valid_bricks_o (valid_bricks_o),
    .total_bricks_o (total_bricks_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off once one is requested.
  always @(posedge clk_i) begin
    if (holdoff_reqs != holdoff_seen) begin
      holdoff_seen <= holdoff_reqs;
      holdoff_left <= HoldoffCycles;
      out_ready_i  <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    brick_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report: expected none, actual valid %0d total %0d",
                 $time, valid_bricks_o, total_bricks_o);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (valid_bricks_o !== want.valid_bricks) begin
          $display("%0t valid_bricks: expected %0d actual %0d",
                   $time, want.valid_bricks, valid_bricks_o);
          errors++;
        end
        if (total_bricks_o !== want.total_bricks) begin
          $display("%0t total_bricks: expected %0d actual %0d",
                   $time, want.total_bricks, total_bricks_o);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned axis_bricks(logic [AxisCntW-1:0] n);
    return (n > MaxBricksPerAxis) ? MaxBricksPerAxis : n;
  endfunction

  // Count one voxel into its brick, close the brick on its far corner, report on last.
  function automatic void count_voxel(logic [ValW-1:0] v, logic [PosW-1:0] px,
                                      logic [PosW-1:0] py, logic [PosW-1:0] pz, logic last);
    int unsigned bx;
    int unsigned by;
    int unsigned bz;
    int unsigned idx;
    int unsigned total;
    brick_report_t rep;
    bx = px / BrickEdge;
    by = py / BrickEdge;
    bz = pz / BrickEdge;
    if (bx < axis_bricks(n_x) && by < axis_bricks(n_y) && bz < axis_bricks(n_z)) begin
      idx = by * MaxBricksPerAxis + bx;
      if (v >= win_low && v <= win_high && occ_count[idx] != CountMax)
        occ_count[idx] = occ_count[idx] + 1'b1;
      if (px % BrickEdge == BrickEdge - 1 && py % BrickEdge == BrickEdge - 1 &&
          pz % BrickEdge == BrickEdge - 1) begin
        if (occ_count[idx] >= min_occ && good_bricks != TallyMax)
          good_bricks = good_bricks + 1'b1;
        occ_count[idx] = '0;
      end
    end
    if (last) begin
      total = axis_bricks(n_x) * axis_bricks(n_y) * axis_bricks(n_z);
      rep.valid_bricks = good_bricks;
      rep.total_bricks = TallyW'(total);
      pending_reports.insert(pending_reports.size(), rep);
      good_bricks = '0;
    end
  endfunction

  task automatic send_voxel(input logic [ValW-1:0] v, input logic [PosW-1:0] px,
                            input logic [PosW-1:0] py, input logic [PosW-1:0] pz,
                            input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    voxel_i      <= v;
    pos_x_i      <= px;
    pos_y_i      <= py;
    pos_z_i      <= pz;
    last_voxel_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    count_voxel(v, px, py, pz, last);
    voxels_sent++;
  endtask

  // Drop valid, wait for every report, then let in-flight counter writes land.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LOW:       win_low  = data[ValW-1:0];
      CFG_HIGH:      win_high = data[ValW-1:0];
      CFG_MIN_COUNT: min_occ  = data[CountW-1:0];
      CFG_BRICKS_X:  n_x      = data[AxisCntW-1:0];
      CFG_BRICKS_Y:  n_y      = data[AxisCntW-1:0];
      CFG_BRICKS_Z:  n_z      = data[AxisCntW-1:0];
      default: ;
    endcase
  endtask

  // Fill the unused upper bits of a narrow register with noise.
  function automatic logic [CfgDataW-1:0] pad_narrow(logic [ValW-1:0] v);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'($urandom);
    word[ValW-1:0] = v;
    return word;
  endfunction

  task automatic configure(input logic [ValW-1:0] low, input logic [ValW-1:0] high,
                           input logic [CountW-1:0] min_cnt, input logic [AxisCntW-1:0] nx,
                           input logic [AxisCntW-1:0] ny, input logic [AxisCntW-1:0] nz);
    write_reg(CFG_LOW, pad_narrow(low));
    write_reg(CFG_HIGH, pad_narrow(high));
    write_reg(CFG_MIN_COUNT, min_cnt);
    write_reg(CFG_BRICKS_X, pad_narrow(nx));
    write_reg(CFG_BRICKS_Y, pad_narrow(ny));
    write_reg(CFG_BRICKS_Z, pad_narrow(nz));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PosW-1:0] brick_coord(int unsigned b, int unsigned off);
    return PosW'(b * BrickEdge + off);
  endfunction

  // Mostly a brick within the configured count, now and then any brick in the store.
  function automatic int unsigned pick_brick(logic [AxisCntW-1:0] n);
    if (axis_bricks(n) == 0 || $urandom_range(9) == 0)
      return $urandom_range(0, MaxBricksPerAxis - 1);
    return $urandom_range(0, axis_bricks(n) - 1);
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(3))
      0:       return win_low;
      1:       return win_high;
      default: return ValW'($urandom);
    endcase
  endfunction

  // A few voxels scattered over one brick, then its far corner.
  task automatic send_brick_visit();
    int unsigned bx;
    int unsigned by;
    int unsigned bz;
    bx = pick_brick(n_x);
    by = pick_brick(n_y);
    bz = pick_brick(n_z);
    repeat ($urandom_range(0, 8))
      send_voxel(pick_value(), brick_coord(bx, $urandom_range(0, BrickEdge - 1)),
                 brick_coord(by, $urandom_range(0, BrickEdge - 1)),
                 brick_coord(bz, $urandom_range(0, BrickEdge - 1)), 1'b0);
    send_voxel(pick_value(), brick_coord(bx, BrickEdge - 1), brick_coord(by, BrickEdge - 1),
               brick_coord(bz, BrickEdge - 1), $urandom_range(99) < 40);
  endtask

  task automatic send_noise();
    send_voxel(ValW'($urandom), PosW'($urandom), PosW'($urandom), PosW'($urandom),
               $urandom_range(99) < 5);
  endtask

  task automatic random_config();
    logic [AxisCntW-1:0] n [3];
    logic [CountW-1:0]   min_cnt;
    settle();
    foreach (n[i])
      n[i] = ($urandom_range(7) == 0) ? AxisCntW'($urandom) : AxisCntW'($urandom_range(1, 4));
    min_cnt = ($urandom_range(7) == 0) ? CountW'($urandom_range(0, 32768))
                                       : CountW'($urandom_range(0, 6));
    configure(ValW'($urandom_range(0, 128)), ValW'($urandom_range(64, 255)), min_cnt,
              n[0], n[1], n[2]);
  endtask

  task automatic test_reset_defaults();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_voxel(8'd10, 12'd0, 12'd5, 12'd3, 1'b0);
    send_voxel(8'd9, 12'd1, 12'd5, 12'd3, 1'b0);
    send_voxel(8'd255, 12'd7, 12'd0, 12'd0, 1'b0);
    send_voxel(8'd0, 12'd31, 12'd31, 12'd31, 1'b0);
    // far corner of the volume lies past the default 124 bricks
    send_voxel(8'd128, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    settle();
  endtask

  task automatic test_window_edges();
    configure(8'd0, 8'd0, 16'd1, 8'd128, 8'd128, 8'd128);
    send_voxel(8'd0, 12'd4064, 12'd4070, 12'd4080, 1'b0);
    send_voxel(8'd255, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    send_voxel(8'd1, 12'd0, 12'd0, 12'd0, 1'b0);
    send_voxel(8'd0, 12'd31, 12'd31, 12'd31, 1'b1);
    settle();
    configure(8'd255, 8'd255, 16'd2, 8'd128, 8'd128, 8'd128);
    send_voxel(8'd255, 12'd32, 12'd40, 12'd2, 1'b0);
    send_voxel(8'd254, 12'd33, 12'd41, 12'd2, 1'b0);
    send_voxel(8'd255, 12'd63, 12'd63, 12'd31, 1'b1);
    settle();
  endtask

  task automatic test_empty_window();
    configure(8'd200, 8'd100, 16'd1, 8'd2, 8'd2, 8'd2);
    send_voxel(8'd100, 12'd32, 12'd0, 12'd40, 1'b0);
    send_voxel(8'd150, 12'd33, 12'd1, 12'd41, 1'b0);
    send_voxel(8'd200, 12'd34, 12'd2, 12'd42, 1'b0);
    send_voxel(8'd0, 12'd63, 12'd31, 12'd63, 1'b1);
    settle();
    configure(8'd200, 8'd100, 16'd0, 8'd2, 8'd2, 8'd2);
    send_voxel(8'd50, 12'd63, 12'd63, 12'd31, 1'b1);
    settle();
  endtask

  task automatic test_axis_limits();
    // zero bricks on x: nothing counts and the total is zero
    configure(8'd0, 8'd255, 16'd0, 8'd0, 8'd5, 8'd5);
    send_voxel(8'd77, 12'd31, 12'd31, 12'd31, 1'b1);
    settle();
    // counts above the store clamp to its size
    configure(8'd0, 8'd255, 16'd0, 8'd200, 8'd1, 8'd255);
    send_voxel(8'd77, 12'd4095, 12'd31, 12'd4095, 1'b0);
    send_voxel(8'd77, 12'd31, 12'd63, 12'd31, 1'b1);
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned in_pct, input int unsigned out_pct);
    int unsigned start;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    repeat (3) begin
      random_config();
      start = voxels_sent;
      while (voxels_sent - start < PhaseItems / 3) begin
        if ($urandom_range(99) < 75)
          send_brick_visit();
        else
          send_noise();
      end
    end
    settle();
  endtask

  // Hold the receiver off while every request ends a volume, so the block backs up.
  task automatic test_report_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    configure(8'd0, 8'd255, 16'd1, 8'd4, 8'd4, 8'd4);
    holdoff_reqs <= holdoff_reqs + 1;
    repeat (40)
      send_voxel(ValW'($urandom), brick_coord(pick_brick(n_x), $urandom_range(30, 31)),
                 brick_coord(pick_brick(n_y), $urandom_range(30, 31)),
                 brick_coord(pick_brick(n_z), $urandom_range(30, 31)), 1'b1);
    settle();
  endtask

  initial begin
    foreach (occ_count[i]) occ_count[i] = '0;
    win_low     = LowReset;
    win_high    = HighReset;
    min_occ     = MinReset;
    n_x         = BricksReset;
    n_y         = BricksReset;
    n_z         = BricksReset;
    good_bricks = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_window_edges();
    test_empty_window();
    test_axis_limits();
    test_random_traffic(0, 0);
    test_random_traffic(66, 0);
    test_random_traffic(0, 66);
    test_random_traffic(13, 13);
    test_report_backpressure();
    settle();

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
